[hdl/lcr_pkg.sv]
// ----------------------------------------------------------------------------
// Line command recogniser package
// Shared types, keyword tables and character matching functions.
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int KW_COUNT          = 3;
  localparam int KW_MAX_LEN        = 5;
  localparam int SHORT_LINE_LIMIT  = 16;

  localparam logic       REQ_DATA          = 1'b0;
  localparam logic       REQ_SESSION_RESET = 1'b1;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  // Keyword letters in upper case; unused tail positions are never compared
  localparam logic [7:0] KW_CHAR [KW_COUNT][KW_MAX_LEN] = '{
    '{"P", "I", "N", "G", 8'h00},
    '{"G", "E", "T", "I", "D"},
    '{"C", "L", "O", "S", "E"}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd5, 3'd5};

  typedef enum logic [1:0] {
    RESP_PONG    = 2'd0,
    RESP_IDENT   = 2'd1,
    RESP_BYE     = 2'd2,
    RESP_UNKNOWN = 2'd3
  } resp_code_e;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'b001,
    PH_TOKEN = 3'b010,
    PH_AFTER = 3'b100
  } phase_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       chunk_last;
  } lcr_item_t;

  typedef struct packed {
    logic       valid;
    resp_code_e code;
  } lcr_result_t;

  // Fold a..z to upper case, leave everything else alone
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] res;
    res = c;
    if (c >= "a" && c <= "z") begin
      res = c - 8'h20;
    end
    return res;
  endfunction

  // Keep flag k only where c matches keyword k at position pos
  function automatic logic [2:0] narrow_flags(input logic [2:0] flags,
                                              input logic [2:0] pos,
                                              input logic [7:0] c);
    logic [2:0] res;
    res = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (flags[k] && pos < KW_LEN[k]) begin
        if (KW_CHAR[k][pos] == c) begin
          res[k] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // First keyword still flagged whose length equals len, else unknown
  function automatic resp_code_e pick_code(input logic [2:0] flags,
                                           input logic [2:0] len);
    resp_code_e res;
    res = RESP_UNKNOWN;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (flags[k] && len == KW_LEN[k]) begin
        res = resp_code_e'(k[1:0]);
      end
    end
    return res;
  endfunction

endpackage

[hdl/lcr_if.sv]
// ----------------------------------------------------------------------------
// Line command recogniser channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface lcr_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       chunk_last;

  modport source (output valid, req_type, data_byte, chunk_last, input ready);
  modport sink   (input valid, req_type, data_byte, chunk_last, output ready);
endinterface

interface lcr_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] response_code;

  modport source (output valid, response_code, input ready);
  modport sink   (input valid, response_code, output ready);
endinterface

[hdl/lcr_core.sv]
// ----------------------------------------------------------------------------
// Line command recogniser parse core
// Holds line state and works out the next state and result for one item.
// ----------------------------------------------------------------------------
module lcr_core import lcr_pkg::*; #(
  parameter int BUFFER_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_en_i,
  input  lcr_item_t   item_i,
  output lcr_result_t result_o
);

  localparam int               FILL_W   = $clog2(BUFFER_BYTES);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BUFFER_BYTES - 1);

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] len_q, len_d;
  phase_e            phase_q, phase_d;
  logic [2:0]        tflags_q, tflags_d;
  logic [2:0]        tpos_q, tpos_d;
  logic [2:0]        rflags_q, rflags_d;

  logic [7:0] upper;
  logic       is_eol;
  logic       is_ws;
  logic       emit;
  resp_code_e code;
  resp_code_e raw_code;
  logic [2:0] len_sat;
  logic [2:0] pos_sat;

  assign upper   = fold_upper(item_i.data_byte);
  assign is_eol  = (item_i.data_byte == CHAR_CR) || (item_i.data_byte == CHAR_LF);
  assign is_ws   = (item_i.data_byte == CHAR_SP) || (item_i.data_byte == CHAR_TAB);
  assign pos_sat = (len_q > FILL_W'(7)) ? 3'd7 : len_q[2:0];

  always_comb begin
    fill_d   = fill_q;
    len_d    = len_q;
    phase_d  = phase_q;
    tflags_d = tflags_q;
    tpos_d   = tpos_q;
    rflags_d = rflags_q;
    emit     = 1'b0;
    code     = RESP_UNKNOWN;
    raw_code = RESP_UNKNOWN;
    len_sat  = 3'd0;

    if (item_i.req_type == REQ_SESSION_RESET) begin
      fill_d   = '0;
      len_d    = '0;
      phase_d  = PH_LEAD;
      tflags_d = '1;
      tpos_d   = '0;
      rflags_d = '1;
    end else begin
      // drop the byte outright once the buffer is full
      if (fill_q != FILL_MAX) begin
        fill_d = fill_q + 1'b1;
        if (is_eol) begin
          if (len_q != '0) begin
            emit = 1'b1;
            code = (phase_q != PH_LEAD) ? pick_code(tflags_q, tpos_q) : RESP_UNKNOWN;
          end
          len_d    = '0;
          phase_d  = PH_LEAD;
          tflags_d = '1;
          tpos_d   = '0;
          rflags_d = '1;
        end else begin
          rflags_d = narrow_flags(rflags_q, pos_sat, upper);
          len_d    = len_q + 1'b1;
          if (is_ws) begin
            if (phase_q == PH_TOKEN) begin
              phase_d = PH_AFTER;
            end
          end else if (phase_q != PH_AFTER) begin
            phase_d  = PH_TOKEN;
            tflags_d = narrow_flags(tflags_q, tpos_q, upper);
            if (tpos_q != 3'd7) begin
              tpos_d = tpos_q + 3'd1;
            end
          end
        end
      end

      // chunk end: dispatch a bare keyword, otherwise carry the partial line
      if (item_i.chunk_last) begin
        len_sat = (len_d > FILL_W'(7)) ? 3'd7 : len_d[2:0];
        if (!emit && len_d != '0 && 32'(len_d) < 32'(SHORT_LINE_LIMIT)) begin
          raw_code = pick_code(rflags_d, len_sat);
          if (raw_code != RESP_UNKNOWN) begin
            emit     = 1'b1;
            code     = raw_code;
            len_d    = '0;
            phase_d  = PH_LEAD;
            tflags_d = '1;
            tpos_d   = '0;
            rflags_d = '1;
          end
        end
        fill_d = len_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      len_q    <= '0;
      phase_q  <= PH_LEAD;
      tflags_q <= '1;
      tpos_q   <= '0;
      rflags_q <= '1;
    end else if (step_en_i) begin
      fill_q   <= fill_d;
      len_q    <= len_d;
      phase_q  <= phase_d;
      tflags_q <= tflags_d;
      tpos_q   <= tpos_d;
      rflags_q <= rflags_d;
    end
  end

  assign result_o.valid = emit;
  assign result_o.code  = code;

endmodule

[hdl/line_command_recognizer.sv]
// ----------------------------------------------------------------------------
// Line command recogniser
// Recognises PING, GETID and CLOSE commands in a chunked byte stream.
// ----------------------------------------------------------------------------
// A result reaches rsp_o through the input register, parse core and result
// register. Throughput: one item per cycle while no response waits unaccepted
// in the result register; the parse core updates all line state in between.
// Reset: rst_ni clears all line state and empties both pipeline registers at
// once; no clearing pass is needed, items are accepted from the first cycle.
module line_command_recognizer import lcr_pkg::*; #(
  parameter int BUFFER_BYTES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcr_req_if.sink   req_i,
  lcr_rsp_if.source rsp_o
);

  // Input register: holds one accepted item for the parse core
  logic        in_valid_q;
  lcr_item_t   in_item_q;

  // Result register: holds one response until the sink takes it
  logic        out_valid_q;
  resp_code_e  out_code_q;

  lcr_result_t result;
  logic        advance;

  // Advance the held item when its result (if any) has somewhere to go;
  // an item that yields nothing never waits on the output side.
  assign advance = in_valid_q && (!result.valid || !out_valid_q || rsp_o.ready);

  // Take a new item whenever the input register is empty or being drained
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_item_q.req_type   <= req_i.req_type;
      in_item_q.data_byte  <= req_i.data_byte;
      in_item_q.chunk_last <= req_i.chunk_last;
    end
  end

  lcr_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_item_q),
    .result_o  (result)
  );

  // Load a fresh response, or drop the old one once it has been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      out_code_q <= result.code;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.response_code = out_code_q;

endmodule

[test/tb_line_command_recognizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line command recogniser testbench
// Drives chunked byte streams and session resets into the recogniser, predicts
// every response from its own line state and checks each one in order.
// ----------------------------------------------------------------------------
module tb_line_command_recognizer;
  import lcr_pkg::*;

  localparam int BUF_BYTES    = 1024;
  // Items of ordinary chunks per random phase; the one full-buffer chunk
  // comes on top
  localparam int PHASE_ITEMS  = 90;
  // Result register sits behind the input register; allow a little slack
  localparam int DRAIN_CYCLES = 4;
  // Cycles with no item moving on either channel before the run is abandoned
  localparam int STALL_LIMIT  = 5000;

  typedef enum logic [1:0] {
    SCAN_LEAD,
    SCAN_WORD,
    SCAN_ARGS
  } scan_e;

  // --------------------------------------------------------------------------
  // Response tracker: mirrors the line state and queues the codes it predicts
  // --------------------------------------------------------------------------
  class lcr_response_tracker;
    int          buf_bytes;
    string       kw [3];
    logic [9:0]  fill;
    logic [9:0]  line_len;
    scan_e       scan;
    logic [2:0]  word_flags;
    logic [2:0]  word_pos;
    logic [2:0]  line_flags;
    resp_code_e  pending_codes [$];
    int          mismatches;
    int          n_items;
    int          n_resets;
    int          n_dropped;
    int          n_chunk_hits;
    int          n_code [4];

    function new(int buffer_bytes);
      buf_bytes = buffer_bytes;
      kw[0] = "PING";
      kw[1] = "GETID";
      kw[2] = "CLOSE";
      fill = '0;
      clear_line();
    endfunction

    function void clear_line();
      line_len   = '0;
      scan       = SCAN_LEAD;
      word_flags = '1;
      word_pos   = '0;
      line_flags = '1;
    endfunction

    function logic [2:0] narrow(logic [2:0] flags, int pos, logic [7:0] c);
      logic [2:0] res;
      res = '0;
      for (int k = 0; k < 3; k++) begin
        if (flags[k] && pos < kw[k].len()) begin
          if (kw[k][pos] == c) begin
            res[k] = 1'b1;
          end
        end
      end
      return res;
    endfunction

    function resp_code_e pick(logic [2:0] flags, int len);
      for (int k = 0; k < 3; k++) begin
        if (flags[k] && len == kw[k].len()) begin
          return resp_code_e'(k);
        end
      end
      return RESP_UNKNOWN;
    endfunction

    function void queue_code(resp_code_e code);
      pending_codes.push_back(code);
      n_code[code]++;
    endfunction

    function int pending();
      return pending_codes.size();
    endfunction

    function void note_item(logic rt, logic [7:0] b, logic last);
      logic [7:0] up;
      logic       answered;
      resp_code_e code;
      n_items++;
      answered = 1'b0;
      if (rt == REQ_SESSION_RESET) begin
        n_resets++;
        fill = '0;
        clear_line();
        return;
      end
      if (int'(fill) < buf_bytes - 1) begin
        fill = fill + 10'd1;
        if (b == CHAR_CR || b == CHAR_LF) begin
          if (line_len != 0) begin
            code = (scan == SCAN_LEAD) ? RESP_UNKNOWN : pick(word_flags, word_pos);
            queue_code(code);
            answered = 1'b1;
          end
          clear_line();
        end else begin
          up = (b >= "a" && b <= "z") ? b - 8'h20 : b;
          line_flags = narrow(line_flags, line_len, up);
          line_len = line_len + 10'd1;
          if (b == CHAR_SP || b == CHAR_TAB) begin
            if (scan == SCAN_WORD) begin
              scan = SCAN_ARGS;
            end
          end else if (scan != SCAN_ARGS) begin
            scan = SCAN_WORD;
            word_flags = narrow(word_flags, word_pos, up);
            if (word_pos < 3'd7) begin
              word_pos = word_pos + 3'd1;
            end
          end
        end
      end else begin
        n_dropped++;
      end
      if (last) begin
        if (!answered && line_len != 0 && line_len < SHORT_LINE_LIMIT) begin
          code = pick(line_flags, line_len);
          if (code != RESP_UNKNOWN) begin
            queue_code(code);
            n_chunk_hits++;
            clear_line();
          end
        end
        fill = line_len;
      end
    endfunction

    // Print only the first few, count them all
    task report_mismatch(string msg);
      if (mismatches < 20) begin
        $display("ERROR: %s", msg);
      end
      mismatches++;
    endtask

    task check_response(logic [1:0] got);
      resp_code_e want;
      if (pending_codes.size() == 0) begin
        report_mismatch($sformatf("response code %0d with no command outstanding", got));
      end else begin
        want = pending_codes.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("response code %0d, wanted %s", got, want.name()));
        end
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  lcr_req_if req_ch ();
  lcr_rsp_if rsp_ch ();

  line_command_recognizer #(
    .BUFFER_BYTES (BUF_BYTES)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  lcr_response_tracker tracker;

  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           stall_cycles = 0;
  logic [7:0]   chunk_q [$];
  string        kw_word [3] = '{"PING", "GETID", "CLOSE"};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: hold ready low on a random share of cycles
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and watchdog: both channels are sampled at the rising edge, so the
  // values seen are those from before the edge's updates
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      // Note the input first so that a same-cycle response would still find it
      if (req_ch.valid && req_ch.ready) begin
        tracker.note_item(req_ch.req_type, req_ch.data_byte, req_ch.chunk_last);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        tracker.check_response(rsp_ch.response_code);
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // Offer one item, idling first at the sender's rate; return at the edge
  // that accepts it, with valid still high
  task automatic send_item(logic rt, logic [7:0] b, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= rt;
    req_ch.data_byte  <= b;
    req_ch.chunk_last <= last;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every predicted response has arrived
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_text(string s, bit end_chunk);
    for (int i = 0; i < s.len(); i++) begin
      send_item(REQ_DATA, s[i], end_chunk && (i == s.len() - 1));
    end
  endtask

  // Send the built chunk, marking its final byte; a session reset may slip in
  task automatic send_chunk(bit allow_reset);
    for (int i = 0; i < chunk_q.size(); i++) begin
      if (allow_reset && $urandom_range(99) == 0) begin
        send_item(REQ_SESSION_RESET, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      send_item(REQ_DATA, chunk_q[i], i == chunk_q.size() - 1);
    end
    chunk_q.delete();
  endtask

  // --------------------------------------------------------------------------
  // Chunk building
  // --------------------------------------------------------------------------
  function automatic logic [7:0] random_letter();
    logic [7:0] c;
    c = 8'h41 + 8'($urandom_range(25));
    if ($urandom_range(1)) begin
      c = c | 8'h20;
    end
    return c;
  endfunction

  function automatic void add_ws(int n);
    repeat (n) chunk_q.push_back($urandom_range(1) ? CHAR_SP : CHAR_TAB);
  endfunction

  // A keyword in random case, mostly exact, sometimes cut short, extended,
  // with one byte replaced, or an unrelated word
  function automatic void add_token();
    int         k;
    int         variant;
    int         n;
    int         hit;
    logic [7:0] c;
    k = $urandom_range(2);
    variant = $urandom_range(9);
    if (variant == 9) begin
      repeat ($urandom_range(1, 9)) chunk_q.push_back(random_letter());
      return;
    end
    n = kw_word[k].len();
    if (variant == 6) begin
      n--;
    end
    hit = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) begin
      c = kw_word[k][i];
      if (variant == 8 && i == hit) begin
        c = 8'($urandom_range(255));
      end else if ($urandom_range(1)) begin
        c = c | 8'h20;
      end
      chunk_q.push_back(c);
    end
    if (variant == 7) begin
      chunk_q.push_back(random_letter());
    end
  endfunction

  function automatic void add_terminator();
    case ($urandom_range(3))
      0: chunk_q.push_back(CHAR_CR);
      1: chunk_q.push_back(CHAR_LF);
      2: begin
        chunk_q.push_back(CHAR_CR);
        chunk_q.push_back(CHAR_LF);
      end
      default: begin
        chunk_q.push_back(CHAR_LF);
        chunk_q.push_back(CHAR_CR);
      end
    endcase
  endfunction

  function automatic void build_line(bit end_line);
    int kind;
    kind = $urandom_range(99);
    // An open line at the chunk end is often a bare keyword for chunk dispatch
    if (!end_line && $urandom_range(1)) begin
      add_token();
      return;
    end
    if (kind < 65) begin
      if ($urandom_range(1)) begin
        add_ws($urandom_range(1, 3));
      end
      add_token();
      if ($urandom_range(99) < 30) begin
        add_ws($urandom_range(1, 2));
        repeat ($urandom_range(1, 8)) chunk_q.push_back(8'($urandom_range(33, 126)));
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 12)) chunk_q.push_back(8'($urandom_range(255)));
    end else if (kind < 95) begin
      add_ws($urandom_range(0, 3));
    end else begin
      // Too long for chunk-end dispatch, and carried on when left open
      repeat ($urandom_range(16, 40)) chunk_q.push_back(8'($urandom_range(33, 126)));
    end
    if (end_line) begin
      add_terminator();
    end
  endfunction

  function automatic void build_chunk();
    int lines;
    lines = $urandom_range(1, 3);
    for (int i = 0; i < lines; i++) begin
      build_line(i < lines - 1 || $urandom_range(99) < 55);
    end
    if (chunk_q.size() == 0) begin
      chunk_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Start clean, fill the buffer with complete lines inside one chunk, then
  // run on with commands and line ends that must all be dropped
  task automatic send_long_chunk();
    send_item(REQ_SESSION_RESET, 8'($urandom_range(255)), 1'($urandom_range(1)));
    while (chunk_q.size() < BUF_BYTES - 1) begin
      build_line(1'b1);
    end
    repeat (4) begin
      add_token();
      add_terminator();
    end
    if ($urandom_range(1)) begin
      add_token();
    end
    send_chunk(1'b0);
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, bit with_long);
    int sent;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    if (with_long) begin
      send_long_chunk();
    end
    while (sent < PHASE_ITEMS) begin
      build_chunk();
      sent += chunk_q.size();
      send_chunk(1'b1);
      // Now and then hold the sender until the block has answered everything
      if ($urandom_range(99) < 3) begin
        wait_for_results();
      end
    end
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_DATA;
    req_ch.data_byte  <= 8'h00;
    req_ch.chunk_last <= 1'b0;
    rst_n             <= 1'b0;
    tracker = new(BUF_BYTES);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty line, whitespace-only line, leading tab with mixed
    // case, chunk-end dispatch, a partial line carried into the next chunk,
    // a session reset with its other fields at their top values, and a line
    // of a zero byte and a high byte
    send_text("\015", 1'b0);
    send_text(" \n", 1'b0);
    send_text("\tpInG\015", 1'b0);
    send_text("cLoSe", 1'b1);
    send_text("GETI", 1'b1);
    send_text("D\n", 1'b0);
    send_item(REQ_SESSION_RESET, 8'hFF, 1'b1);
    send_item(REQ_DATA, 8'h00, 1'b0);
    send_item(REQ_DATA, 8'hFF, 1'b0);
    send_item(REQ_DATA, CHAR_CR, 1'b1);
    wait_for_results();

    // Random: receiver-heavy idling, then sender-heavy, then none with the
    // full-buffer chunk
    run_phase(35, 49, 1'b0);
    run_phase(49, 35, 1'b0);
    run_phase(0, 0, 1'b1);

    if (tracker.pending() != 0) begin
      tracker.report_mismatch($sformatf("%0d responses never arrived", tracker.pending()));
    end
    $display("Run covered %0d items, %0d of them session resets, %0d bytes dropped %s",
             tracker.n_items, tracker.n_resets, tracker.n_dropped, "at a full buffer.");
    $display("Responses: %0d pong, %0d ident, %0d bye, %0d unknown; %0d at chunk end.",
             tracker.n_code[RESP_PONG], tracker.n_code[RESP_IDENT], tracker.n_code[RESP_BYE],
             tracker.n_code[RESP_UNKNOWN], tracker.n_chunk_hits);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/lcr_pkg.sv
hdl/lcr_if.sv
hdl/lcr_core.sv
hdl/line_command_recognizer.sv
test/tb_line_command_recognizer.sv
